>>> design/fbia_pkg.sv
// Shared widths, command codes and saturation helper for the fractional buffer block.
`timescale 1ns / 1ps
`default_nettype none

package fbia_pkg;

  // Field widths fixed by the request and result formats
  localparam int SAMPLE_W = 24;
  localparam int OFFSET_W = 40;
  localparam int LEN_W    = 13;

  // Scaled weighted term and the widened sum before clamping
  localparam int TERM_W = SAMPLE_W + 2;
  localparam int SAT_W  = SAMPLE_W + 3;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

  // Command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Clamp a widened sum into the signed sample range
  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SAT_W-1:0] x);
    logic hi_ovf;
    logic lo_ovf;
    hi_ovf = !x[SAT_W-1] && (x[SAT_W-2:SAMPLE_W-1] != '0);
    lo_ovf = x[SAT_W-1] && (x[SAT_W-2:SAMPLE_W-1] != '1);
    if (hi_ovf) begin
      sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (lo_ovf) begin
      sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_sample = x[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/fbia_req_if.sv
// Request channel: command, fixed-point offset and sample to splat.
`timescale 1ns / 1ps
`default_nettype none

interface fbia_req_if import fbia_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic signed [OFFSET_W-1:0] offset;
  logic signed [SAMPLE_W-1:0] write_sample;

  modport source (output valid, cmd, offset, write_sample, input ready);
  modport sink   (input valid, cmd, offset, write_sample, output ready);
endinterface

`default_nettype wire

>>> design/fbia_rsp_if.sv
// Response channel: interpolated read sample.
`timescale 1ns / 1ps
`default_nettype none

interface fbia_rsp_if import fbia_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] read_sample;

  modport source (output valid, read_sample, input ready);
  modport sink   (input valid, read_sample, output ready);
endinterface

`default_nettype wire

>>> design/fbia_ram.sv
// Single-port sample memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fbia_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/fbia_wrap.sv
// Iterative floor-modulo of the offset's integer part by the buffer length.
`timescale 1ns / 1ps
`default_nettype none

module fbia_wrap import fbia_pkg::*; #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int FRAC_BITS    = 16,
  localparam int IW = OFFSET_W - FRAC_BITS,
  localparam int LW = $clog2(BUFFER_DEPTH + 1),
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [OFFSET_W-1:0]  offset_i,
  input  wire logic [LW-1:0]        len_i,
  output logic                      done_o,
  output logic      [AW-1:0]        idx_p_o,
  output logic      [AW-1:0]        idx_q_o,
  output logic      [FRAC_BITS-1:0] frac_o
);

  localparam int CW = $clog2(IW + 1);

  typedef enum logic [1:0] {
    W_IDLE,
    W_STEP,
    W_FIX
  } wrap_state_e;

  wrap_state_e   state_q;
  logic [IW-1:0] mag_q;
  logic [LW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;

  logic [IW-1:0] ip;
  logic [IW-1:0] mag_start;
  logic [LW:0]   trial;
  logic [LW-1:0] rem_d;
  logic [LW-1:0] pval;
  logic [LW-1:0] qnext;

  // Magnitude of the signed integer part
  assign ip        = offset_i[OFFSET_W-1:FRAC_BITS];
  assign mag_start = ip[IW-1] ? IW'(~ip + IW'(1)) : ip;

  // One restoring step: bring in the next bit, subtract the length if it fits
  always_comb begin
    trial = {rem_q, mag_q[IW-1]};
    if (trial >= {1'b0, len_i}) begin
      rem_d = LW'(trial - {1'b0, len_i});
    end else begin
      rem_d = trial[LW-1:0];
    end
  end

  // Fold a negative remainder back into range and find the next index
  always_comb begin
    if (neg_q && (rem_q != '0)) begin
      pval = len_i - rem_q;
    end else begin
      pval = rem_q;
    end
    qnext = pval + LW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_o  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        W_IDLE: begin
          if (start_i) begin
            mag_q   <= mag_start;
            neg_q   <= ip[IW-1];
            frac_o  <= offset_i[FRAC_BITS-1:0];
            rem_q   <= '0;
            cnt_q   <= CW'(IW);
            state_q <= W_STEP;
          end
        end
        W_STEP: begin
          rem_q <= rem_d;
          mag_q <= {mag_q[IW-2:0], 1'b0};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= W_FIX;
          end
        end
        W_FIX: begin
          idx_p_o <= pval[AW-1:0];
          idx_q_o <= (qnext == len_i) ? '0 : qnext[AW-1:0];
          done_o  <= 1'b1;
          state_q <= W_IDLE;
        end
        default: begin
          state_q <= W_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/fractional_buffer_interp_access.sv
// Top level: circular sample store with interpolated read and splatting write.
//
// Usage:
//   req channel carries cmd, a signed offset with FRAC_BITS fraction bits and
//   a sample; rsp channel returns read_sample for reads only. Writes give no
//   response. buffer_length is written through cfg_we_i / cfg_wdata_i while
//   the block is idle, a rule for the user that the block does not enforce;
//   0 acts as 1 and values above BUFFER_DEPTH as the depth.
// Sequencing:
//   one request at a time, req.ready high only when idle. The offset wrap
//   runs one remainder bit a cycle over the 40 - FRAC_BITS integer bits, a
//   fix step folds the remainder and hands the indexes over, then a shared
//   multiplier and the single memory port do the reads, products and writes.
// Reset:
//   the store is swept to zero one entry a cycle over all BUFFER_DEPTH entries,
//   with req.ready low; configuration writes are taken meanwhile.
// Stalls:
//   the result sits in an output register; the next request is accepted while
//   it waits, and a following read holds in its final cycle until taken.
`timescale 1ns / 1ps
`default_nettype none

module fractional_buffer_interp_access import fbia_pkg::*; #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  fbia_req_if.sink              req,
  fbia_rsp_if.source            rsp
);

  localparam int LW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int KW = FRAC_BITS + 2;
  localparam int PW = SAMPLE_W + KW;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_RD_P,
    S_RD_Q,
    S_MUL_B,
    S_SUM,
    S_WR_MUL,
    S_WR_P,
    S_WR_RQ,
    S_WR_Q
  } seq_state_e;

  seq_state_e           state_q;
  seq_state_e           state_d;
  logic [LEN_W-1:0]     len_q;
  logic [LW-1:0]        len_eff;
  logic [AW-1:0]        clr_q;
  logic                 cmd_q;
  logic [SAMPLE_W-1:0]  wsamp_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] acc_q;
  logic                 out_valid_q;
  logic [SAMPLE_W-1:0]  out_data_q;

  logic                 accept;
  logic                 wrap_done;
  logic [AW-1:0]        idx_p;
  logic [AW-1:0]        idx_q;
  logic [FRAC_BITS-1:0] frac;
  logic [FRAC_BITS:0]   om_frac;

  logic                 ram_en;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [SAMPLE_W-1:0]  ram_wdata;
  logic [SAMPLE_W-1:0]  ram_rdata;

  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [KW-1:0]       mul_b;
  logic signed [PW-1:0]       prod_d;
  logic [TERM_W-1:0]          term;
  logic [SAT_W-1:0]           upd;
  logic [PW:0]                mix;
  logic                       out_free;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid       = out_valid_q;
  assign rsp.read_sample = out_data_q;

  // Clamp the configured length into 1..BUFFER_DEPTH
  always_comb begin
    if (len_q == '0) begin
      len_eff = LW'(1);
    end else if (32'(len_q) > 32'(BUFFER_DEPTH)) begin
      len_eff = LW'(BUFFER_DEPTH);
    end else begin
      len_eff = LW'(len_q);
    end
  end

  fbia_wrap #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .offset_i (req.offset),
    .len_i    (len_eff),
    .done_o   (wrap_done),
    .idx_p_o  (idx_p),
    .idx_q_o  (idx_q),
    .frac_o   (frac)
  );

  fbia_ram #(
    .DEPTH (BUFFER_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign om_frac = ONE - {1'b0, frac};

  // Shared multiplier: pick sample and weight by step
  always_comb begin
    mul_a = signed'(wsamp_q);
    mul_b = signed'({1'b0, om_frac});
    case (state_q)
      S_RD_Q: begin
        mul_a = signed'(ram_rdata);
        mul_b = signed'({1'b0, om_frac});
      end
      S_MUL_B: begin
        mul_a = signed'(ram_rdata);
        mul_b = signed'({2'b00, frac});
      end
      S_WR_P: begin
        mul_a = signed'(wsamp_q);
        mul_b = signed'({2'b00, frac});
      end
      default: begin
        mul_a = signed'(wsamp_q);
        mul_b = signed'({1'b0, om_frac});
      end
    endcase
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  // Scale the product down, add to the stored entry, and mix two products
  assign term = prod_q[PW-1:FRAC_BITS];
  assign upd  = {{3{ram_rdata[SAMPLE_W-1]}}, ram_rdata} + {term[TERM_W-1], term};
  assign mix  = {acc_q[PW-1], acc_q} + {prod_q[PW-1], prod_q};
  assign out_free = !out_valid_q || rsp.ready;

  // Sequence the memory port and next state
  always_comb begin
    state_d   = state_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = idx_p;
    ram_wdata = sat_sample(upd);
    case (state_q)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        if (clr_q == AW'(BUFFER_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if (wrap_done) begin
          state_d = (cmd_q == CMD_WRITE) ? S_WR_MUL : S_RD_P;
        end
      end
      S_RD_P: begin
        ram_en  = 1'b1;
        state_d = S_RD_Q;
      end
      S_RD_Q: begin
        ram_en   = 1'b1;
        ram_addr = idx_q;
        state_d  = S_MUL_B;
      end
      S_MUL_B: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_WR_MUL: begin
        ram_en  = 1'b1;
        state_d = S_WR_P;
      end
      S_WR_P: begin
        ram_en  = 1'b1;
        ram_we  = 1'b1;
        state_d = S_WR_RQ;
      end
      S_WR_RQ: begin
        ram_en   = 1'b1;
        ram_addr = idx_q;
        state_d  = S_WR_Q;
      end
      S_WR_Q: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = idx_q;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, configuration, operands and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      len_q       <= LEN_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (accept) begin
        cmd_q   <= req.cmd;
        wsamp_q <= req.write_sample;
      end
      if (state_q == S_RD_Q || state_q == S_MUL_B ||
          state_q == S_WR_MUL || state_q == S_WR_P) begin
        prod_q <= prod_d;
      end
      if (state_q == S_MUL_B) begin
        acc_q <= prod_q;
      end
      if (state_q == S_SUM && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= mix[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/fbia_checker.sv
// Port-level checks on the fractional buffer block, attached by bind.
`timescale 1ns / 1ps
`default_nettype none

module fbia_checker import fbia_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                req_valid_i,
  input wire logic                req_ready_i,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic [SAMPLE_W-1:0] rsp_read_sample_i
);

  // Block goes busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready stayed high after a request was taken");

  // A new result only comes out of a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result appeared without a request in progress");

  // A pending result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_read_sample_i))
    else $error("result changed while stalled");

endmodule

bind fractional_buffer_interp_access fbia_checker u_fbia_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_read_sample_i (rsp.read_sample)
);

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the fractional-position interpolating sample store.
`timescale 1ns / 1ps

module tb import fbia_pkg::*;;

  localparam int DEPTH = 4096;
  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;
  // Long enough for a request to finish, with some margin
  localparam int SETTLE_CYCLES = 48;
  // Room for the reset sweep, which idles the request side while it clears every entry
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 75;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    bit                         is_len;
    logic [LEN_W-1:0]           len;
    logic                       cmd;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         has_fixed;
    logic signed [SAMPLE_W-1:0] fixed_val;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [LEN_W-1:0] cfg_wdata_i = LEN_RESET;

  fbia_req_if req_ch ();
  fbia_rsp_if rsp_ch ();

  fractional_buffer_interp_access #(
    .BUFFER_DEPTH(DEPTH),
    .FRAC_BITS   (FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // Shadow copy of the store and the length register
  logic signed [SAMPLE_W-1:0] shadow_store [DEPTH];
  logic [LEN_W-1:0]           shadow_len;
  logic signed [SAMPLE_W-1:0] pending_reads [$];
  int                         mismatches = 0;
  int                         burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp length into 1..DEPTH
  function automatic int unsigned active_len();
    if (shadow_len == 0) return 1;
    if (shadow_len > DEPTH) return DEPTH;
    return shadow_len;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint x);
    if (x > SAMPLE_HI) return SAMPLE_W'(SAMPLE_HI);
    if (x < SAMPLE_LO) return SAMPLE_W'(SAMPLE_LO);
    return SAMPLE_W'(x);
  endfunction

  // Wrap the position (floor modulo) and find the entry pair and fraction
  function automatic void locate_pair(input logic signed [OFFSET_W-1:0] off,
                                      output int unsigned p, output int unsigned q,
                                      output longint frac);
    int unsigned len;
    longint      span;
    longint      r;
    len = active_len();
    span = longint'(len) << FRAC;
    r = longint'(off) % span;
    if (r < 0) r += span;
    p = int'(r >>> FRAC);
    frac = r & (ONE - 1);
    if (p >= len) p = len - 1;
    q = p + 1;
    if (q >= len) q = 0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] interp_sample(
      input logic signed [OFFSET_W-1:0] off);
    int unsigned p;
    int unsigned q;
    longint      frac;
    longint      v;
    locate_pair(off, p, q, frac);
    v = (longint'(shadow_store[p]) * (ONE - frac) + longint'(shadow_store[q]) * frac) >>> FRAC;
    return SAMPLE_W'(v);
  endfunction

  // Split the sample over the pair; with one entry both parts land in turn
  function automatic void splat_sample(input logic signed [OFFSET_W-1:0] off,
                                       input logic signed [SAMPLE_W-1:0] w);
    int unsigned p;
    int unsigned q;
    longint      frac;
    longint      lo;
    longint      hi;
    locate_pair(off, p, q, frac);
    lo = (longint'(w) * (ONE - frac)) >>> FRAC;
    hi = (longint'(w) * frac) >>> FRAC;
    shadow_store[p] = clamp_sample(longint'(shadow_store[p]) + lo);
    shadow_store[q] = clamp_sample(longint'(shadow_store[q]) + hi);
  endfunction

  function automatic stim_row_t op_row(input logic cmd, input longint off, input longint smp,
                                       input bit has_fixed = 1'b0,
                                       input longint fixed_val = 0);
    stim_row_t r;
    r.is_len = 1'b0;
    r.len = '0;
    r.cmd = cmd;
    r.offset = OFFSET_W'(off);
    r.sample = SAMPLE_W'(smp);
    r.has_fixed = has_fixed;
    r.fixed_val = SAMPLE_W'(fixed_val);
    return r;
  endfunction

  function automatic stim_row_t len_row(input int len);
    stim_row_t r;
    r = op_row(CMD_READ, 0, 0);
    r.is_len = 1'b1;
    r.len = LEN_W'(len);
    return r;
  endfunction

  // Send one request in bursts with random gaps, then update the shadow state
  task automatic send_req(input logic cmd, input logic signed [OFFSET_W-1:0] off,
                          input logic signed [SAMPLE_W-1:0] smp,
                          input bit has_fixed, input logic signed [SAMPLE_W-1:0] fixed_val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.offset <= off;
    req_ch.write_sample <= smp;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    burst_left--;
    if (cmd == CMD_READ) begin
      pending_reads.push_back(has_fixed ? fixed_val : interp_sample(off));
    end else begin
      splat_sample(off, smp);
    end
  endtask

  // Hold requests until every read has returned; optionally let a write finish
  task automatic hold_until_drained(input bit settle);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_reads.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    hold_until_drained(1'b1);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_len = len;
  endtask

  // Response side: stall in modes of random length, check each response
  initial begin
    int stall_mode;
    int mode_left;
    stall_mode = 0;
    mode_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected response: read_sample %0d", rsp_ch.read_sample);
        end else begin
          if (rsp_ch.read_sample !== pending_reads[0]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("read_sample mismatch: expected %0d, got %0d",
                       pending_reads[0], rsp_ch.read_sample);
          end
          void'(pending_reads.pop_front());
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          rsp_ch.ready <= 1'b1;
        end
        1: begin
          rsp_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t                  rows [$];
    int unsigned                len_eff;
    int unsigned                base;
    int unsigned                p;
    int                         wraps;
    int                         sel;
    int                         pause_at;
    longint                     pos;
    logic [LEN_W-1:0]           len;
    logic                       cmd;
    logic signed [OFFSET_W-1:0] off;
    logic signed [SAMPLE_W-1:0] smp;

    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_READ;
    req_ch.offset = '0;
    req_ch.write_sample = '0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_len = LEN_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: reset contents, extremes, wrap, negative positions, lengths
    rows.push_back(op_row(CMD_READ, 0, 0, 1'b1, 0));
    rows.push_back(op_row(CMD_READ, 64'sh7F_FFFF_FFFF, 0, 1'b1, 0));
    rows.push_back(op_row(CMD_READ, -64'sh80_0000_0000, 0, 1'b1, 0));
    rows.push_back(op_row(CMD_WRITE, 0, SAMPLE_HI));
    rows.push_back(op_row(CMD_READ, 0, 0, 1'b1, SAMPLE_HI));
    rows.push_back(op_row(CMD_WRITE, 0, SAMPLE_HI));
    rows.push_back(op_row(CMD_READ, 0, 0, 1'b1, SAMPLE_HI));
    rows.push_back(op_row(CMD_WRITE, (10 <<< FRAC) + 32768, SAMPLE_LO));
    rows.push_back(op_row(CMD_READ, (10 <<< FRAC) + 32768, 0));
    rows.push_back(op_row(CMD_READ, (10 <<< FRAC) + 16384, SAMPLE_HI));
    rows.push_back(op_row(CMD_WRITE, (64'sd4095 <<< FRAC) + 49152, -1));
    rows.push_back(op_row(CMD_READ, (64'sd4095 <<< FRAC) + 49152, 0));
    rows.push_back(op_row(CMD_READ, -ONE, 0));
    rows.push_back(op_row(CMD_READ, -1, 0));
    rows.push_back(len_row(1));
    rows.push_back(op_row(CMD_WRITE, 12345, 5000));
    rows.push_back(op_row(CMD_WRITE, -777, SAMPLE_LO));
    rows.push_back(op_row(CMD_READ, -777, 0));
    rows.push_back(len_row(0));
    rows.push_back(op_row(CMD_READ, 64'sh7F_FFFF_FFFF, 0));
    rows.push_back(len_row(8191));
    rows.push_back(op_row(CMD_READ, 64'sd4096 <<< FRAC, 0));
    rows.push_back(len_row(3));
    rows.push_back(op_row(CMD_WRITE, -1, SAMPLE_LO));
    rows.push_back(op_row(CMD_WRITE, -1, SAMPLE_LO));
    rows.push_back(op_row(CMD_READ, (2 <<< FRAC) + 32768, 0));
    rows.push_back(op_row(CMD_READ, -32768, 0));

    foreach (rows[i]) begin
      if (rows[i].is_len) begin
        write_length(rows[i].len);
      end else begin
        send_req(rows[i].cmd, rows[i].offset, rows[i].sample, rows[i].has_fixed,
                 rows[i].fixed_val);
      end
    end

    // Random phases, each under its own length setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: len = LEN_W'(DEPTH);
        1: len = 1;
        2: len = 2;
        3: len = 0;
        4: len = '1;
        5: len = LEN_W'(DEPTH - 1);
        6: len = 3;
        7: len = LEN_W'(DEPTH + 1);
        default: len = (ph % 2 == 0) ? LEN_W'($urandom_range(1, 64)) : LEN_W'($urandom);
      endcase
      write_length(len);
      len_eff = active_len();
      base = $urandom_range(0, len_eff - 1);
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == pause_at) hold_until_drained(1'b0);
        if ($urandom_range(0, 15) == 0) base = $urandom_range(0, len_eff - 1);
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          // Near a working window, a few laps either side of the range
          p = (base + $urandom_range(0, 15)) % len_eff;
          wraps = int'($urandom_range(0, 4)) - 2;
          pos = (longint'(wraps) * longint'(len_eff) + longint'(p)) <<< FRAC;
          case ($urandom_range(0, 3))
            0: pos += 0;
            1: pos += ONE - 1;
            default: pos += longint'($urandom_range(0, 65535));
          endcase
          off = OFFSET_W'(pos);
        end else if (sel < 80) begin
          off = OFFSET_W'(-longint'($urandom_range(1, 1 << 20)));
        end else begin
          off = OFFSET_W'({$urandom, $urandom});
        end
        cmd = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0: smp = SAMPLE_W'(SAMPLE_HI);
          1: smp = SAMPLE_W'(SAMPLE_LO);
          default: smp = SAMPLE_W'($urandom);
        endcase
        send_req(cmd, off, smp, 1'b0, '0);
      end
    end

    hold_until_drained(1'b1);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> fractional_buffer_interp_access.f
design/fbia_pkg.sv
design/fbia_req_if.sv
design/fbia_rsp_if.sv
design/fbia_ram.sv
design/fbia_wrap.sv
design/fractional_buffer_interp_access.sv
design/fbia_checker.sv
dv/tb.sv
